[rtl/ready_queue_scheduler_mlfq_core_defines.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef READY_QUEUE_SCHEDULER_MLFQ_CORE_DEFINES_SVH
`define READY_QUEUE_SCHEDULER_MLFQ_CORE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define RQS_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("scheduler check failed");

// The condition must hold in the cycle after the trigger.
`define RQS_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("scheduler check failed");

`endif

[rtl/rqs_pkg.sv]
// Shared types, codes and helper functions of the ready queue scheduler.
`timescale 1ns / 1ps
package rqs_pkg;

    localparam int NUM_THREADS = 16;
    localparam int NUM_LEVELS  = 8;

    localparam logic signed [8:0] FRESH_BUDGET = 9'sd8;

    localparam logic [2:0] OP_ADMIT    = 3'd0;
    localparam logic [2:0] OP_READY    = 3'd1;
    localparam logic [2:0] OP_DISPATCH = 3'd2;
    localparam logic [2:0] OP_WORK     = 3'd3;
    localparam logic [2:0] OP_YIELD    = 3'd4;
    localparam logic [2:0] OP_BLOCK    = 3'd5;
    localparam logic [2:0] OP_TICK     = 3'd6;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_NORUN = 2'd2;

    localparam logic [1:0] MODE_RR   = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_MLFQ = 2'd2;

    localparam logic [2:0] CFG_POLICY   = 3'd0;
    localparam logic [2:0] CFG_LEVELS   = 3'd1;
    localparam logic [2:0] CFG_QUANTUM  = 3'd2;
    localparam logic [2:0] CFG_AGING_EN = 3'd3;
    localparam logic [2:0] CFG_AGING_IV = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [3:0] tid;
        logic [3:0] prio;
        logic [2:0] level;
    } entry_t;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INSERT,
        CO_REMOVE
    } cell_op_t;

    typedef enum logic [1:0] {
        RM_HEAD,
        RM_TID,
        RM_LEVEL
    } rm_sel_t;

    typedef struct packed {
        cell_op_t   kind;
        rm_sel_t    rm;
        logic [1:0] pol;
        entry_t     key;
    } cmd_t;

    function automatic logic signed [8:0] quantum_of(input logic [63:0] tab,
                                                     input logic [2:0] lvl);
        logic [7:0] q;
        q = tab[{lvl, 3'b000} +: 8];
        if (q == 8'd0)
        begin
            q = 8'd1;
        end
        return $signed({1'b0, q});
    endfunction

endpackage

[rtl/rqs_cell.sv]
// One cell of the ready chain: holds one queued thread and shifts with its neighbours.
`timescale 1ns / 1ps
module rqs_cell import rqs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  entry_t left,
    input  entry_t right,
    input  logic   found_in,
    output entry_t q,
    output logic   found_out,
    output logic   hit
);

    entry_t content_reg;
    entry_t content_next;
    logic   match;
    logic   ins_here;

    always_comb
    begin
        case (cmd.rm)
            RM_TID:   match = content_reg.valid && (content_reg.tid == cmd.key.tid);
            RM_LEVEL: match = content_reg.valid && (content_reg.level == cmd.key.level);
            default:  match = content_reg.valid;
        endcase
        ins_here = !content_reg.valid
                   || ((cmd.pol == MODE_PRIO) && (cmd.key.prio > content_reg.prio))
                   || ((cmd.pol == MODE_MLFQ) && (cmd.key.level < content_reg.level));
        content_next = content_reg;
        found_out    = found_in;
        hit          = 1'b0;
        case (cmd.kind)
            CO_INSERT:
            begin
                found_out = found_in || ins_here;
                if (found_in)
                begin
                    content_next = left;
                end
                else if (ins_here)
                begin
                    content_next = cmd.key;
                end
            end
            CO_REMOVE:
            begin
                found_out = found_in || match;
                hit       = match && !found_in;
                if (found_in || match)
                begin
                    content_next = right;
                end
            end
            default:
            begin
                content_next = content_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            content_reg <= '0;
        end
        else
        begin
            content_reg <= content_next;
        end
    end

    assign q = content_reg;

endmodule

[rtl/ready_queue_scheduler_mlfq_core.sv]
// Top level of the ready queue scheduler: command sequencer, thread tables and cell chain.
// From an accepted start the sequencer steps through S_EXEC to decode, S_ENQ for a queue
// insertion and S_DISP for a dispatch removal, then S_DONE, which registers the done beat.
// A new command is taken only once the sequencer is idle again; the next start is taken in the done cycle.
// The done beat cannot be stalled by the receiver.
// Reset empties the chain, clears levels to zero, sets all budgets to eight and loads defaults.
`timescale 1ns / 1ps
`include "ready_queue_scheduler_mlfq_core_defines.svh"
module ready_queue_scheduler_mlfq_core import rqs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        operation,
    input  logic [3:0]        thread_id,
    input  logic [3:0]        priority_req,
    input  logic [7:0]        work_units,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output logic              done,
    output logic [1:0]        status,
    output logic [3:0]        out_thread,
    output logic signed [8:0] budget_left,
    output logic              expired
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENQ,
        S_DISP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [3:0]  tid_reg, tid_next;
    logic [3:0]  preq_reg, preq_next;
    logic [7:0]  units_reg, units_next;
    logic [3:0]  enq_tid_reg, enq_tid_next;
    logic        disp_after_reg, disp_after_next;
    logic [3:0]  who_reg, who_next;
    logic        have_reg, have_next;
    logic [1:0]  status_reg, status_next;
    logic        expired_reg, expired_next;
    logic        run_valid_reg, run_valid_next;
    logic [3:0]  run_id_reg, run_id_next;
    logic [15:0] aging_cnt_reg, aging_cnt_next;
    logic        done_reg, done_next;
    logic [1:0]  status_o_reg, status_o_next;
    logic [3:0]  thread_o_reg, thread_o_next;
    logic signed [8:0] budget_o_reg, budget_o_next;
    logic        expired_o_reg, expired_o_next;

    logic [1:0]  policy_reg;
    logic [3:0]  level_count_reg;
    logic [63:0] quantum_reg;
    logic        aging_en_reg;
    logic [15:0] aging_iv_reg;

    logic [2:0]        lvl_tab_reg [NUM_THREADS];
    logic signed [8:0] bud_tab_reg [NUM_THREADS];
    logic [3:0]        pri_tab_reg [NUM_THREADS];

    logic              lvl_we, bud_we, pri_we;
    logic [3:0]        lvl_wa, bud_wa, pri_wa;
    logic [2:0]        lvl_wd;
    logic signed [8:0] bud_wd;
    logic [3:0]        pri_wd;

    cmd_t   cmd;
    entry_t cell_q [NUM_THREADS];
    entry_t cell_left [NUM_THREADS];
    entry_t cell_right [NUM_THREADS];
    logic [NUM_THREADS:0]   found;
    logic [NUM_THREADS-1:0] hit;
    logic [NUM_THREADS-1:0] cell_valid;
    logic [NUM_THREADS:0]   chain_fill;

    logic [3:0]        hit_tid;
    logic [2:0]        hit_lvl;
    logic [NUM_LEVELS-1:0] pres;
    logic              tid_in_chain, run_in_chain;
    logic [1:0]        mode;
    logic [3:0]        lc_eff;
    logic [2:0]        lcm1;
    logic [2:0]        min_lvl;
    logic [2:0]        age_lvl;
    logic              age_found;
    logic [15:0]       aging_iv_eff;
    logic [15:0]       cnt_inc;
    logic [7:0]        units_eff;
    logic signed [9:0] work_b;
    logic signed [8:0] work_sat;
    logic [3:0]        nl;
    logic [2:0]        nl_c;
    logic [2:0]        enq_lvl;
    logic [2:0]        enq_lvl_c;
    logic [3:0]        preq_c;

    genvar g;
    generate
        for (g = 0; g < NUM_THREADS; g++)
        begin : g_chain
            if (g == 0)
            begin : g_head
                assign cell_left[g] = '0;
            end
            else
            begin : g_body
                assign cell_left[g] = cell_q[g-1];
            end
            if (g == NUM_THREADS - 1)
            begin : g_tail
                assign cell_right[g] = '0;
            end
            else
            begin : g_mid
                assign cell_right[g] = cell_q[g+1];
            end
            rqs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (cell_left[g]),
                .right     (cell_right[g]),
                .found_in  (found[g]),
                .q         (cell_q[g]),
                .found_out (found[g+1]),
                .hit       (hit[g])
            );
            assign cell_valid[g] = cell_q[g].valid;
        end
    endgenerate

    assign found[0]   = 1'b0;
    assign chain_fill = {1'b0, cell_valid} + {{NUM_THREADS{1'b0}}, 1'b1};

    always_comb
    begin
        hit_tid      = '0;
        hit_lvl      = '0;
        pres         = '0;
        tid_in_chain = 1'b0;
        run_in_chain = 1'b0;
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            if (hit[i])
            begin
                hit_tid = hit_tid | cell_q[i].tid;
                hit_lvl = hit_lvl | cell_q[i].level;
            end
            if (cell_q[i].valid)
            begin
                pres[cell_q[i].level] = 1'b1;
                if (cell_q[i].tid == tid_reg)
                begin
                    tid_in_chain = 1'b1;
                end
                if (cell_q[i].tid == run_id_reg)
                begin
                    run_in_chain = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        mode = (policy_reg == 2'd3) ? MODE_RR : policy_reg;
        if (level_count_reg == 4'd0)
        begin
            lc_eff = 4'd1;
        end
        else if (level_count_reg > 4'(NUM_LEVELS))
        begin
            lc_eff = 4'(NUM_LEVELS);
        end
        else
        begin
            lc_eff = level_count_reg;
        end
        lcm1 = 3'(lc_eff - 4'd1);
        min_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (pres[l])
            begin
                min_lvl = 3'(l);
            end
        end
        age_lvl   = '0;
        age_found = 1'b0;
        for (int l = 1; l < NUM_LEVELS; l++)
        begin
            if (pres[l] && (3'(l) <= lcm1))
            begin
                age_lvl   = 3'(l);
                age_found = 1'b1;
            end
        end
        aging_iv_eff = (aging_iv_reg == 16'd0) ? 16'd1 : aging_iv_reg;
        cnt_inc      = aging_cnt_reg + 16'd1;
        units_eff    = (units_reg == 8'd0) ? 8'd1 : units_reg;
        work_b       = {bud_tab_reg[run_id_reg][8], bud_tab_reg[run_id_reg]}
                       - $signed({2'b00, units_eff});
        work_sat     = (work_b < -10'sd255) ? -9'sd255 : work_b[8:0];
        nl           = {1'b0, lvl_tab_reg[run_id_reg]} + 4'd1;
        nl_c         = (nl > {1'b0, lcm1}) ? lcm1 : nl[2:0];
        enq_lvl      = lvl_tab_reg[enq_tid_reg];
        enq_lvl_c    = (enq_lvl > lcm1) ? lcm1 : enq_lvl;
        if (preq_reg == 4'd0)
        begin
            preq_c = 4'd1;
        end
        else if (preq_reg > 4'd10)
        begin
            preq_c = 4'd10;
        end
        else
        begin
            preq_c = preq_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        tid_next        = tid_reg;
        preq_next       = preq_reg;
        units_next      = units_reg;
        enq_tid_next    = enq_tid_reg;
        disp_after_next = disp_after_reg;
        who_next        = who_reg;
        have_next       = have_reg;
        status_next     = status_reg;
        expired_next    = expired_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        aging_cnt_next  = aging_cnt_reg;
        done_next       = 1'b0;
        status_o_next   = status_o_reg;
        thread_o_next   = thread_o_reg;
        budget_o_next   = budget_o_reg;
        expired_o_next  = expired_o_reg;
        cmd.kind        = CO_HOLD;
        cmd.rm          = RM_HEAD;
        cmd.pol         = mode;
        cmd.key         = '0;
        lvl_we = 1'b0;
        bud_we = 1'b0;
        pri_we = 1'b0;
        lvl_wa = tid_reg;
        bud_wa = tid_reg;
        pri_wa = tid_reg;
        lvl_wd = '0;
        bud_wd = FRESH_BUDGET;
        pri_wd = preq_c;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = operation;
                    tid_next        = thread_id;
                    preq_next       = priority_req;
                    units_next      = work_units;
                    have_next       = 1'b0;
                    who_next        = '0;
                    status_next     = STATUS_OK;
                    expired_next    = 1'b0;
                    disp_after_next = 1'b0;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_ADMIT:
                    begin
                        cmd.kind    = CO_REMOVE;
                        cmd.rm      = RM_TID;
                        cmd.key.tid = tid_reg;
                        if (run_valid_reg && (run_id_reg == tid_reg))
                        begin
                            run_valid_next = 1'b0;
                        end
                        pri_we       = 1'b1;
                        lvl_we       = 1'b1;
                        bud_we       = 1'b1;
                        who_next     = tid_reg;
                        have_next    = 1'b1;
                        enq_tid_next = tid_reg;
                        state_next   = S_ENQ;
                    end
                    OP_READY:
                    begin
                        who_next  = tid_reg;
                        have_next = 1'b1;
                        if (!tid_in_chain)
                        begin
                            if (run_valid_reg && (run_id_reg == tid_reg))
                            begin
                                run_valid_next = 1'b0;
                            end
                            enq_tid_next = tid_reg;
                            state_next   = S_ENQ;
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (run_valid_reg)
                        begin
                            run_valid_next  = 1'b0;
                            enq_tid_next    = run_id_reg;
                            disp_after_next = 1'b1;
                            state_next      = S_ENQ;
                        end
                        else
                        begin
                            state_next = S_DISP;
                        end
                    end
                    OP_WORK, OP_YIELD, OP_BLOCK:
                    begin
                        if (!run_valid_reg)
                        begin
                            status_next = STATUS_NORUN;
                        end
                        else
                        begin
                            who_next  = run_id_reg;
                            have_next = 1'b1;
                            lvl_wa    = run_id_reg;
                            bud_wa    = run_id_reg;
                            if (op_reg == OP_WORK)
                            begin
                                bud_we = 1'b1;
                                bud_wd = work_sat;
                                if (work_sat <= 9'sd0)
                                begin
                                    expired_next = 1'b1;
                                    if (mode == MODE_MLFQ)
                                    begin
                                        lvl_we = 1'b1;
                                        lvl_wd = nl_c;
                                        bud_wd = quantum_of(quantum_reg, nl_c);
                                    end
                                    run_valid_next = 1'b0;
                                    enq_tid_next   = run_id_reg;
                                    state_next     = S_ENQ;
                                end
                            end
                            else if (op_reg == OP_YIELD)
                            begin
                                run_valid_next = 1'b0;
                                enq_tid_next   = run_id_reg;
                                state_next     = S_ENQ;
                            end
                            else
                            begin
                                if (mode == MODE_MLFQ)
                                begin
                                    lvl_we = 1'b1;
                                    bud_we = 1'b1;
                                    lvl_wd = (lvl_tab_reg[run_id_reg] == 3'd0) ? 3'd0
                                             : lvl_tab_reg[run_id_reg] - 3'd1;
                                    bud_wd = quantum_of(quantum_reg, lvl_wd);
                                end
                                run_valid_next = 1'b0;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        if ((mode == MODE_MLFQ) && aging_en_reg)
                        begin
                            aging_cnt_next = cnt_inc;
                            if (cnt_inc >= aging_iv_eff)
                            begin
                                aging_cnt_next = '0;
                                if (age_found)
                                begin
                                    cmd.kind      = CO_REMOVE;
                                    cmd.rm        = RM_LEVEL;
                                    cmd.key.level = age_lvl;
                                    who_next      = hit_tid;
                                    have_next     = 1'b1;
                                    lvl_we        = 1'b1;
                                    lvl_wa        = hit_tid;
                                    lvl_wd        = age_lvl - 3'd1;
                                    enq_tid_next  = hit_tid;
                                    state_next    = S_ENQ;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ENQ:
            begin
                lvl_wa = enq_tid_reg;
                bud_wa = enq_tid_reg;
                cmd.key.valid = 1'b1;
                cmd.key.tid   = enq_tid_reg;
                cmd.key.prio  = pri_tab_reg[enq_tid_reg];
                cmd.key.level = enq_lvl;
                if (mode == MODE_MLFQ)
                begin
                    lvl_we        = 1'b1;
                    bud_we        = 1'b1;
                    lvl_wd        = enq_lvl_c;
                    bud_wd        = quantum_of(quantum_reg, enq_lvl_c);
                    cmd.key.level = enq_lvl_c;
                end
                if (!cell_valid[NUM_THREADS-1])
                begin
                    cmd.kind = CO_INSERT;
                end
                state_next = disp_after_reg ? S_DISP : S_DONE;
            end
            S_DISP:
            begin
                state_next = S_DONE;
                if (!cell_valid[0])
                begin
                    status_next = STATUS_EMPTY;
                    who_next    = '0;
                    have_next   = 1'b0;
                end
                else
                begin
                    cmd.kind = CO_REMOVE;
                    if (mode == MODE_MLFQ)
                    begin
                        cmd.rm        = RM_LEVEL;
                        cmd.key.level = min_lvl;
                    end
                    who_next       = hit_tid;
                    have_next      = 1'b1;
                    bud_we         = 1'b1;
                    bud_wa         = hit_tid;
                    bud_wd         = (mode == MODE_MLFQ) ? quantum_of(quantum_reg, hit_lvl)
                                                         : FRESH_BUDGET;
                    run_valid_next = 1'b1;
                    run_id_next    = hit_tid;
                end
            end
            S_DONE:
            begin
                done_next      = 1'b1;
                status_o_next  = status_reg;
                thread_o_next  = have_reg ? who_reg : 4'd0;
                budget_o_next  = have_reg ? bud_tab_reg[who_reg] : 9'sd0;
                expired_o_next = expired_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_valid_reg  <= 1'b0;
            aging_cnt_reg  <= '0;
            done_reg       <= 1'b0;
            disp_after_reg <= 1'b0;
            have_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_valid_reg  <= run_valid_next;
            aging_cnt_reg  <= aging_cnt_next;
            done_reg       <= done_next;
            disp_after_reg <= disp_after_next;
            have_reg       <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tid_reg       <= tid_next;
        preq_reg      <= preq_next;
        units_reg     <= units_next;
        enq_tid_reg   <= enq_tid_next;
        who_reg       <= who_next;
        status_reg    <= status_next;
        expired_reg   <= expired_next;
        run_id_reg    <= run_id_next;
        status_o_reg  <= status_o_next;
        thread_o_reg  <= thread_o_next;
        budget_o_reg  <= budget_o_next;
        expired_o_reg <= expired_o_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= MODE_RR;
            level_count_reg <= 4'd3;
            quantum_reg     <= 64'h0808080808080808;
            aging_en_reg    <= 1'b1;
            aging_iv_reg    <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY:   policy_reg      <= cfg_data[1:0];
                CFG_LEVELS:   level_count_reg <= cfg_data[3:0];
                CFG_QUANTUM:  quantum_reg     <= cfg_data;
                CFG_AGING_EN: aging_en_reg    <= cfg_data[0];
                CFG_AGING_IV: aging_iv_reg    <= cfg_data[15:0];
                default:
                begin
                    policy_reg <= policy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                lvl_tab_reg[i] <= '0;
                bud_tab_reg[i] <= FRESH_BUDGET;
            end
        end
        else
        begin
            if (lvl_we)
            begin
                lvl_tab_reg[lvl_wa] <= lvl_wd;
            end
            if (bud_we)
            begin
                bud_tab_reg[bud_wa] <= bud_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pri_we)
        begin
            pri_tab_reg[pri_wa] <= pri_wd;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_o_reg;
    assign out_thread  = thread_o_reg;
    assign budget_left = budget_o_reg;
    assign expired     = expired_o_reg;

    `RQS_ASSERT_IMP(a_done_when_idle, done_reg, state_reg == S_IDLE)
    `RQS_ASSERT_NXT(a_start_goes_busy, start && !busy, busy)
    `RQS_ASSERT_IMP(a_chain_packed, 1'b1, $onehot(chain_fill))
    `RQS_ASSERT_IMP(a_running_not_queued, run_valid_reg, !run_in_chain)

endmodule
